>>> hw/rtl/xlsu_pkg.sv
package xlsu_pkg;

    typedef enum logic [3:0] {
        KIND_TEST   = 4'd0,
        KIND_AND    = 4'd1,
        KIND_XOR    = 4'd2,
        KIND_OR     = 4'd3,
        KIND_SAR    = 4'd4,
        KIND_SHL    = 4'd5,
        KIND_SHR    = 4'd6,
        KIND_ROL    = 4'd7,
        KIND_SETCC  = 4'd8,
        KIND_BSR    = 4'd9,
        KIND_NOT    = 4'd10,
        KIND_LDFLG  = 4'd11
    } t_kind;

    localparam logic [1:0] WC_BYTE = 2'd0;
    localparam logic [1:0] WC_WORD = 2'd1;

    localparam logic [2:0] CC_O   = 3'd0;
    localparam logic [2:0] CC_B   = 3'd1;
    localparam logic [2:0] CC_Z   = 3'd2;
    localparam logic [2:0] CC_BE  = 3'd3;
    localparam logic [2:0] CC_S   = 3'd4;
    localparam logic [2:0] CC_P   = 3'd5;
    localparam logic [2:0] CC_L   = 3'd6;
    localparam logic [2:0] CC_LE  = 3'd7;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 5;

    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic cf;
    } t_flags;

    typedef struct packed {
        logic [3:0]        flags_in;
        logic [3:0]        cond_code;
        logic [DATA_W-1:0] src_value;
        logic [DATA_W-1:0] dest_value;
        logic [1:0]        width_code;
        logic [3:0]        kind;
    } t_op;

    typedef struct packed {
        logic              cond_error;
        t_flags            flags;
        logic              write_dest;
        logic [DATA_W-1:0] result_value;
    } t_res;

endpackage

>>> hw/rtl/xlsu_alu.sv
module xlsu_alu (
    input  xlsu_pkg::t_op    i_op,
    input  xlsu_pkg::t_flags i_flags,
    output xlsu_pkg::t_res   o_res
);
    import xlsu_pkg::*;

    logic [DATA_W-1:0]        mask;
    logic [DATA_W-1:0]        d;
    logic [DATA_W-1:0]        s;
    logic [CNT_W-1:0]         cnt;
    logic [DATA_W-1:0]        r_and;
    logic [DATA_W-1:0]        r_xor;
    logic [DATA_W-1:0]        r_or;
    logic                     d_top;
    logic signed [DATA_W-1:0] d_ext;
    logic [DATA_W-1:0]        sar_val;
    logic [CNT_W-1:0]         rot_cnt;
    logic [2*DATA_W-1:0]      rot_wide;
    logic [DATA_W-1:0]        rol_val;
    logic                     cond_raw;
    logic                     cond_bad;
    logic [CNT_W-1:0]         bsr_idx;
    logic [DATA_W-1:0]        logic_val;
    logic                     logic_top;

    always_comb begin
        case (i_op.width_code)
            WC_BYTE: mask = 32'h0000_00ff;
            WC_WORD: mask = 32'h0000_ffff;
            default: mask = 32'hffff_ffff;
        endcase
    end

    assign d     = i_op.dest_value & mask;
    assign s     = i_op.src_value & mask;
    assign cnt   = i_op.src_value[CNT_W-1:0];
    assign r_and = d & s;
    assign r_xor = d ^ s;
    assign r_or  = d | s;

    always_comb begin
        case (i_op.width_code)
            WC_BYTE: d_top = d[7];
            WC_WORD: d_top = d[15];
            default: d_top = d[31];
        endcase
    end

    assign d_ext   = d_top ? $signed(d | ~mask) : $signed(d);
    assign sar_val = DATA_W'(d_ext >>> cnt) & mask;

    always_comb begin
        case (i_op.width_code)
            WC_BYTE: begin
                rot_cnt  = {2'b00, cnt[2:0]};
                rot_wide = 64'({d[7:0], d[7:0]}) << rot_cnt;
                rol_val  = {24'd0, rot_wide[15:8]};
            end
            WC_WORD: begin
                rot_cnt  = {1'b0, cnt[3:0]};
                rot_wide = 64'({d[15:0], d[15:0]}) << rot_cnt;
                rol_val  = {16'd0, rot_wide[31:16]};
            end
            default: begin
                rot_cnt  = cnt;
                rot_wide = {d, d} << rot_cnt;
                rol_val  = rot_wide[63:32];
            end
        endcase
    end

    always_comb begin
        cond_bad = 1'b0;
        case (i_op.cond_code[3:1])
            CC_O:    cond_raw = i_flags.of;
            CC_B:    cond_raw = i_flags.cf;
            CC_Z:    cond_raw = i_flags.zf;
            CC_BE:   cond_raw = i_flags.cf | i_flags.zf;
            CC_S:    cond_raw = i_flags.sf;
            CC_P: begin
                cond_raw = 1'b0;
                cond_bad = 1'b1;
            end
            CC_L:    cond_raw = i_flags.sf ^ i_flags.of;
            CC_LE:   cond_raw = i_flags.zf | (i_flags.sf ^ i_flags.of);
            default: cond_raw = 1'b0;
        endcase
    end

    always_comb begin
        bsr_idx = '0;
        for (int i = 0; i < DATA_W; i++) begin
            if (s[i]) begin
                bsr_idx = CNT_W'(i);
            end
        end
    end

    always_comb begin
        case (i_op.kind)
            KIND_XOR: logic_val = r_xor;
            KIND_OR:  logic_val = r_or;
            default:  logic_val = r_and;
        endcase
        case (i_op.width_code)
            WC_BYTE: logic_top = logic_val[7];
            WC_WORD: logic_top = logic_val[15];
            default: logic_top = logic_val[31];
        endcase
    end

    always_comb begin
        o_res.result_value = '0;
        o_res.write_dest   = 1'b0;
        o_res.flags        = i_flags;
        o_res.cond_error   = 1'b0;
        case (i_op.kind)
            KIND_TEST, KIND_AND, KIND_XOR, KIND_OR: begin
                if (i_op.kind != KIND_TEST) begin
                    o_res.result_value = logic_val;
                    o_res.write_dest   = 1'b1;
                end
                o_res.flags.zf = (logic_val == '0);
                o_res.flags.sf = logic_top;
                o_res.flags.cf = 1'b0;
                o_res.flags.of = 1'b0;
            end
            KIND_SAR: begin
                o_res.result_value = sar_val;
                o_res.write_dest   = 1'b1;
            end
            KIND_SHL: begin
                o_res.result_value = (d << cnt) & mask;
                o_res.write_dest   = 1'b1;
            end
            KIND_SHR: begin
                o_res.result_value = d >> cnt;
                o_res.write_dest   = 1'b1;
            end
            KIND_ROL: begin
                if (rot_cnt != '0) begin
                    o_res.result_value = rol_val;
                    o_res.write_dest   = 1'b1;
                end
            end
            KIND_SETCC: begin
                if (cond_bad) begin
                    o_res.cond_error = 1'b1;
                end else begin
                    o_res.result_value = DATA_W'(cond_raw ^ i_op.cond_code[0]);
                    o_res.write_dest   = 1'b1;
                end
            end
            KIND_BSR: begin
                if (s == '0) begin
                    o_res.flags.zf = 1'b1;
                end else begin
                    o_res.result_value = DATA_W'(bsr_idx);
                    o_res.write_dest   = 1'b1;
                    o_res.flags.zf     = 1'b0;
                end
            end
            KIND_NOT: begin
                o_res.result_value = ~d & mask;
                o_res.write_dest   = 1'b1;
            end
            KIND_LDFLG: begin
                o_res.flags = t_flags'(i_op.flags_in);
            end
            default: begin
                o_res.result_value = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/x86_logic_shift_unit_core.sv
// Channel   Dir  tdata (low bit up)                       tuser (low bit up)
// s_axis    in   dest_value, src_value, cond_code,        kind, width_code
//                flags_in (72 bits)
// m_axis    out  result_value, flags_out, 4 pad (40 bits) write_dest, cond_error
//
// One word per cycle sustained while m_axis_tready is high; the output is registered.
// The input register feeds the combinational ALU; the flag register updates as a word
// moves into the output register, so the next word sees those flags.
// Synchronous active-low reset clears valids and flags to zero.
// A stalled output holds one word while the input register holds the next.
module x86_logic_shift_unit_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // dest_value, src_value, cond_code, flags_in
    input  logic [5:0]  s_axis_tuser,   // kind, width_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // result_value, flags_out, zero pad
    output logic [1:0]  m_axis_tuser    // write_dest, cond_error
);
    import xlsu_pkg::*;

    logic   r_in_valid;
    logic   r_out_valid;
    t_flags r_flags;
    t_op    r_op;
    t_res   r_res;
    t_res   n_res;
    logic   advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    xlsu_alu u_alu (
        .i_op    (r_op),
        .i_flags (r_flags),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_res.flags;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op <= {s_axis_tdata, s_axis_tuser};
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_res.flags, r_res.result_value};
    assign m_axis_tuser  = {r_res.cond_error, r_res.write_dest};

endmodule

>>> test/x86_logic_shift_unit_core_tb.sv
`timescale 1ns / 100ps

module x86_logic_shift_unit_core_tb;

    import xlsu_pkg::*;

    localparam logic [1:0] WC_DWORD = 2'd2;
    localparam logic [1:0] WC_WIDE  = 2'd3;

    localparam logic [3:0] KIND_SPARE_LO = 4'd12;
    localparam logic [3:0] KIND_SPARE_HI = 4'd15;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // dest_value, src_value, cond_code, flags_in
    logic [5:0]  s_axis_tuser;   // kind, width_code
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // result_value, flags_out, zero pad
    logic [1:0]  m_axis_tuser;   // write_dest, cond_error

    t_flags flags_q;
    t_res   pending_results[$];
    int     mismatches;
    bit     steady;

    x86_logic_shift_unit_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic void set_logic_flags(logic [31:0] r, int unsigned bits);
        flags_q.zf = (r == 32'd0);
        flags_q.sf = r[bits-1];
        flags_q.cf = 1'b0;
        flags_q.of = 1'b0;
    endfunction

    function automatic t_res exec_logic_op(t_op op);
        t_res        res;
        int unsigned bits;
        int unsigned rot;
        logic [31:0] mask;
        logic [31:0] d;
        logic [31:0] s;
        logic [31:0] sx;
        logic [4:0]  cnt;
        logic        cond;
        res = '0;
        case (op.width_code)
            WC_BYTE: bits = 8;
            WC_WORD: bits = 16;
            default: bits = 32;
        endcase
        mask = (bits == 32) ? 32'hffff_ffff : ((32'd1 << bits) - 32'd1);
        d    = op.dest_value & mask;
        s    = op.src_value & mask;
        cnt  = op.src_value[4:0];
        case (op.kind)
            KIND_TEST: begin
                set_logic_flags(d & s, bits);
            end
            KIND_AND, KIND_XOR, KIND_OR: begin
                if (op.kind == KIND_AND) res.result_value = d & s;
                else if (op.kind == KIND_XOR) res.result_value = d ^ s;
                else res.result_value = d | s;
                res.write_dest = 1'b1;
                set_logic_flags(res.result_value, bits);
            end
            KIND_SAR: begin
                sx = d[bits-1] ? (d | ~mask) : d;
                res.result_value = $unsigned($signed(sx) >>> cnt) & mask;
                res.write_dest = 1'b1;
            end
            KIND_SHL: begin
                res.result_value = (d << cnt) & mask;
                res.write_dest = 1'b1;
            end
            KIND_SHR: begin
                res.result_value = d >> cnt;
                res.write_dest = 1'b1;
            end
            KIND_ROL: begin
                rot = cnt % bits;
                if (rot != 0) begin
                    res.result_value = ((d << rot) | (d >> (bits - rot))) & mask;
                    res.write_dest = 1'b1;
                end
            end
            KIND_SETCC: begin
                case (op.cond_code[3:1])
                    CC_O:    cond = flags_q.of;
                    CC_B:    cond = flags_q.cf;
                    CC_Z:    cond = flags_q.zf;
                    CC_BE:   cond = flags_q.cf | flags_q.zf;
                    CC_S:    cond = flags_q.sf;
                    CC_P:    cond = 1'b0;
                    CC_L:    cond = flags_q.sf ^ flags_q.of;
                    default: cond = flags_q.zf | (flags_q.sf ^ flags_q.of);
                endcase
                if (op.cond_code[3:1] == CC_P) begin
                    res.cond_error = 1'b1;
                end else begin
                    res.result_value = {31'd0, cond ^ op.cond_code[0]};
                    res.write_dest = 1'b1;
                end
            end
            KIND_BSR: begin
                if (s == 32'd0) begin
                    flags_q.zf = 1'b1;
                end else begin
                    for (int i = bits - 1; i >= 0; i--) begin
                        if (s[i]) begin
                            res.result_value = i;
                            break;
                        end
                    end
                    res.write_dest = 1'b1;
                    flags_q.zf = 1'b0;
                end
            end
            KIND_NOT: begin
                res.result_value = ~d & mask;
                res.write_dest = 1'b1;
            end
            KIND_LDFLG: begin
                flags_q = t_flags'(op.flags_in);
            end
            default: ;
        endcase
        res.flags = flags_q;
        return res;
    endfunction

    function automatic t_op make_op(logic [3:0] kind, logic [1:0] wc, logic [31:0] d,
                                    logic [31:0] s, logic [3:0] cc, logic [3:0] fl);
        t_op op;
        op.kind       = kind;
        op.width_code = wc;
        op.dest_value = d;
        op.src_value  = s;
        op.cond_code  = cc;
        op.flags_in   = fl;
        return op;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hffff_ffff;
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return $urandom ^ (32'h8000_8080 & $urandom);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_op rand_op(logic [3:0] kind);
        return make_op(kind, 2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                       4'($urandom), 4'($urandom));
    endfunction

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_op(t_op op);
        bit taken;
        if (!steady && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {op.flags_in, op.cond_code, op.src_value, op.dest_value};
        s_axis_tuser  <= {op.width_code, op.kind};
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        pending_results.push_back(exec_logic_op(op));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp, act);
            mismatches++;
        end
    endtask

    initial begin
        t_res exp;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected word, expected none actual %h/%h", $time,
                             m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end else begin
                    exp = pending_results.pop_front();
                    check_field("result_value", exp.result_value, m_axis_tdata[31:0]);
                    check_field("flags_out", 32'(exp.flags), 32'(m_axis_tdata[35:32]));
                    check_field("write_dest", 32'(exp.write_dest), 32'(m_axis_tuser[0]));
                    check_field("cond_error", 32'(exp.cond_error), 32'(m_axis_tuser[1]));
                end
            end
        end
    end

    initial begin
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!steady && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic test_logic_ops();
        send_op(make_op(KIND_AND, WC_BYTE, 32'hffff_ff80, 32'hffff_fff0, 4'd0, 4'd0));
        send_op(make_op(KIND_TEST, WC_WORD, 32'h0000_ffff, 32'h0000_0000, 4'd0, 4'd0));
        send_op(make_op(KIND_XOR, WC_DWORD, 32'hffff_ffff, 32'h7fff_ffff, 4'd0, 4'd0));
        send_op(make_op(KIND_OR, WC_WIDE, 32'h0000_0000, 32'h0000_0000, 4'd0, 4'd0));
    endtask

    task automatic test_shifts();
        send_op(make_op(KIND_SAR, WC_BYTE, 32'h0000_0080, 32'h0000_0023, 4'd0, 4'd0));
        send_op(make_op(KIND_SAR, WC_WORD, 32'h0000_8000, 32'h0000_001f, 4'd0, 4'd0));
        send_op(make_op(KIND_SAR, WC_DWORD, 32'h7fff_ffff, 32'hffff_ffe0, 4'd0, 4'd0));
        send_op(make_op(KIND_SHL, WC_DWORD, 32'h0000_0001, 32'h0000_001f, 4'd0, 4'd0));
        send_op(make_op(KIND_SHL, WC_BYTE, 32'h0000_00ff, 32'h0000_0008, 4'd0, 4'd0));
        send_op(make_op(KIND_SHR, WC_WORD, 32'hffff_ffff, 32'h0000_000f, 4'd0, 4'd0));
    endtask

    task automatic test_rotate();
        send_op(make_op(KIND_ROL, WC_BYTE, 32'h0000_0081, 32'h0000_0008, 4'd0, 4'd0));
        send_op(make_op(KIND_ROL, WC_BYTE, 32'h0000_0081, 32'h0000_0009, 4'd0, 4'd0));
        send_op(make_op(KIND_ROL, WC_WORD, 32'h0000_8001, 32'hffff_ffff, 4'd0, 4'd0));
        send_op(make_op(KIND_ROL, WC_DWORD, 32'h1234_5678, 32'h0000_0020, 4'd0, 4'd0));
    endtask

    task automatic test_bsr_not();
        send_op(make_op(KIND_BSR, WC_DWORD, 32'h0, 32'h0000_0000, 4'd0, 4'd0));
        send_op(make_op(KIND_BSR, WC_BYTE, 32'h0, 32'h0000_0100, 4'd0, 4'd0));
        send_op(make_op(KIND_BSR, WC_DWORD, 32'h0, 32'h8000_0001, 4'd0, 4'd0));
        send_op(make_op(KIND_NOT, WC_WORD, 32'h1234_00ff, 32'h0, 4'd0, 4'd0));
    endtask

    task automatic test_setcc_flags();
        send_op(make_op(KIND_LDFLG, WC_BYTE, 32'h0, 32'h0, 4'd0, 4'hf));
        send_op(make_op(KIND_SETCC, WC_BYTE, 32'h0, 32'h0, {CC_P, 1'b0}, 4'd0));
        send_op(make_op(KIND_SETCC, WC_BYTE, 32'h0, 32'h0, {CC_P, 1'b1}, 4'd0));
        send_op(make_op(KIND_SETCC, WC_BYTE, 32'h0, 32'h0, {CC_LE, 1'b1}, 4'd0));
        send_op(make_op(KIND_LDFLG, WC_BYTE, 32'h0, 32'h0, 4'd0, 4'h0));
        send_op(make_op(KIND_SETCC, WC_BYTE, 32'h0, 32'h0, {CC_O, 1'b0}, 4'd0));
        send_op(make_op(KIND_SPARE_LO, WC_DWORD, 32'hffff_ffff, 32'h1, 4'd0, 4'd0));
        send_op(make_op(KIND_SPARE_HI, WC_DWORD, 32'hffff_ffff, 32'h1, 4'hf, 4'hf));
    endtask

    task automatic test_random_mix(int count);
        logic [3:0] kind;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 19) == 0) kind = 4'($urandom_range(KIND_SPARE_LO, 15));
            else kind = 4'($urandom_range(0, KIND_LDFLG));
            send_op(rand_op(kind));
        end
    endtask

    // load flags, then read them back through a run of setcc, bsr and logic ops
    task automatic test_flag_sequences(int runs);
        for (int n = 0; n < runs; n++) begin
            send_op(rand_op(KIND_LDFLG));
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 3) == 0)
                    send_op(rand_op(4'($urandom_range(KIND_TEST, KIND_OR))));
                else if ($urandom_range(0, 5) == 0)
                    send_op(rand_op(KIND_BSR));
                else
                    send_op(rand_op(KIND_SETCC));
            end
        end
    endtask

    initial begin
        mismatches = 0;
        steady     = 1'b0;
        flags_q    = '0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_logic_ops();
        test_shifts();
        test_rotate();
        test_bsr_not();
        test_setcc_flags();
        drain_results();

        test_random_mix(500);
        test_flag_sequences(50);
        steady = 1'b1;
        test_random_mix(200);
        drain_results();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
